FILE: src/bgd_pkg.sv
`timescale 1ns / 1ps

package bgd_pkg;

	// Fixed hold limits in ms
	localparam logic [11:0] BGD_TAP_MAX_MS = 12'd1000;
	localparam logic [11:0] BGD_HINT1_LO   = 12'd1000;
	localparam logic [11:0] BGD_HINT1_HI   = 12'd1100;
	localparam logic [11:0] BGD_HINT2_LO   = 12'd2000;
	localparam logic [11:0] BGD_HINT2_HI   = 12'd2100;

	localparam int unsigned BGD_CFG_IDX_BITS  = 3;
	localparam int unsigned BGD_CFG_DATA_BITS = 16;

	typedef enum logic [BGD_CFG_IDX_BITS-1:0] {
		BGD_REG_ENABLE        = 3'd0,
		BGD_REG_TAP_MIN       = 3'd1,
		BGD_REG_DOUBLE_WINDOW = 3'd2,
		BGD_REG_TRIPLE_WINDOW = 3'd3,
		BGD_REG_LONG_PRESS    = 3'd4,
		BGD_REG_TAPS_NEEDED   = 3'd5
	} bgd_reg_idx_t;

	typedef enum logic [1:0] {
		BGD_HINT_NONE  = 2'd0,
		BGD_HINT_FIRST = 2'd1,
		BGD_HINT_SECOND = 2'd2
	} bgd_hint_t;

	typedef struct packed {
		logic        enable;
		logic [9:0]  tap_min_ms;
		logic [15:0] double_window_ms;
		logic [15:0] triple_window_ms;
		logic [15:0] long_hold_ms;
		logic [3:0]  taps_needed;
	} bgd_cfg_t;

	typedef struct packed {
		logic tap;
		logic pending;
		logic double_tap;
	} bgd_first_res_t;

	typedef struct packed {
		logic       tap;
		logic [3:0] tally;
		logic       multi_tap;
		logic       long_press;
		bgd_hint_t  hint;
	} bgd_second_res_t;

endpackage

FILE: src/bgd_in_if.sv
`timescale 1ns / 1ps

interface bgd_in_if;
	logic        valid;
	logic        ready;
	logic        first_pressed;
	logic        second_pressed;
	logic [31:0] now_ms;

	modport source (output valid, output first_pressed, output second_pressed,
		output now_ms, input ready);
	modport sink (input valid, input first_pressed, input second_pressed,
		input now_ms, output ready);
endinterface

FILE: src/bgd_out_if.sv
`timescale 1ns / 1ps

interface bgd_out_if;
	logic       valid;
	logic       ready;
	logic       first_tap;
	logic       first_tap_pending;
	logic       double_tap;
	logic       second_tap;
	logic [3:0] tap_tally;
	logic       multi_tap;
	logic       long_press;
	logic [1:0] hold_hint;

	modport source (output valid, output first_tap, output first_tap_pending,
		output double_tap, output second_tap, output tap_tally, output multi_tap,
		output long_press, output hold_hint, input ready);
	modport sink (input valid, input first_tap, input first_tap_pending,
		input double_tap, input second_tap, input tap_tally, input multi_tap,
		input long_press, input hold_hint, output ready);
endinterface

FILE: src/bgd_first.sv
`timescale 1ns / 1ps

// First button: tap qualification and double-tap pairing.
module bgd_first #(
	parameter int unsigned STAMP_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  bgd_pkg::bgd_cfg_t       cfg,
	input  logic                    pressed,
	input  logic [STAMP_BITS-1:0]   now,
	output bgd_pkg::bgd_first_res_t res
);

	logic                  held_q;
	logic [STAMP_BITS-1:0] press_stamp_q;
	logic                  pend_q;
	logic [STAMP_BITS-1:0] pair_stamp_q;

	logic [STAMP_BITS-1:0] hold_el;
	logic [STAMP_BITS-1:0] pair_el;
	logic                  rise;
	logic                  fall;
	logic                  valid_tap;
	logic                  pair_late;
	logic                  pend_d;

	assign hold_el   = now - press_stamp_q;
	assign pair_el   = now - pair_stamp_q;
	assign rise      = pressed && !held_q;
	assign fall      = !pressed && held_q;
	assign valid_tap = fall && (hold_el >= STAMP_BITS'(cfg.tap_min_ms))
		&& (hold_el < STAMP_BITS'(bgd_pkg::BGD_TAP_MAX_MS));
	assign pair_late = pair_el > STAMP_BITS'(cfg.double_window_ms);

	// a tap that opens a pair has age zero, so only an older pair can time out
	assign pend_d = valid_tap ? !pend_q : (pend_q && !pair_late);

	always_comb begin
		res = '0;
		if (cfg.enable && valid_tap) begin
			res.tap        = 1'b1;
			res.pending    = !pend_q;
			res.double_tap = pend_q && !pair_late;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q        <= 1'b0;
			press_stamp_q <= '0;
			pend_q        <= 1'b0;
			pair_stamp_q  <= '0;
		end else if (step && cfg.enable) begin
			if (rise) begin
				held_q        <= 1'b1;
				press_stamp_q <= now;
			end else if (fall) begin
				held_q <= 1'b0;
			end
			if (valid_tap && !pend_q) begin
				pair_stamp_q <= now;
			end
			pend_q <= pend_d;
		end
	end

endmodule

FILE: src/bgd_second.sv
`timescale 1ns / 1ps

// Second button: long press, hold hints and multi-tap counting.
module bgd_second #(
	parameter int unsigned STAMP_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  bgd_pkg::bgd_cfg_t        cfg,
	input  logic                     pressed,
	input  logic [STAMP_BITS-1:0]    now,
	output bgd_pkg::bgd_second_res_t res
);

	logic                  held_q;
	logic [STAMP_BITS-1:0] press_stamp_q;
	logic                  long_fired_q;
	logic [3:0]            count_q;
	logic [STAMP_BITS-1:0] count_stamp_q;

	logic [STAMP_BITS-1:0] hold_el;
	logic [STAMP_BITS-1:0] count_el;
	logic                  holding;
	logic                  long_hit;
	logic                  valid_tap;
	logic                  count_zero;
	logic                  in_window;
	logic [3:0]            count_inc;
	logic                  multi;
	logic [3:0]            count_d;
	logic                  restamp;
	bgd_pkg::bgd_hint_t    hint;

	assign hold_el    = now - press_stamp_q;
	assign count_el   = now - count_stamp_q;
	assign holding    = pressed && held_q && !long_fired_q;
	assign long_hit   = holding && (hold_el >= STAMP_BITS'(cfg.long_hold_ms));
	assign valid_tap  = !pressed && held_q && !long_fired_q
		&& (hold_el >= STAMP_BITS'(cfg.tap_min_ms))
		&& (hold_el < STAMP_BITS'(bgd_pkg::BGD_TAP_MAX_MS));
	assign count_zero = count_q == 4'd0;
	assign in_window  = count_zero || (count_el <= STAMP_BITS'(cfg.triple_window_ms));
	assign count_inc  = in_window ? count_q + 4'd1 : 4'd1;
	assign multi      = count_inc >= cfg.taps_needed;
	assign restamp    = valid_tap && !(in_window && !count_zero);

	always_comb begin
		if (valid_tap) begin
			count_d = multi ? 4'd0 : count_inc;
		end else if (!count_zero
			&& (count_el > STAMP_BITS'(cfg.triple_window_ms))) begin
			count_d = 4'd0;
		end else begin
			count_d = count_q;
		end
	end

	always_comb begin
		hint = bgd_pkg::BGD_HINT_NONE;
		if (holding) begin
			if (hold_el >= STAMP_BITS'(bgd_pkg::BGD_HINT1_LO)
				&& hold_el < STAMP_BITS'(bgd_pkg::BGD_HINT1_HI)) begin
				hint = bgd_pkg::BGD_HINT_FIRST;
			end else if (hold_el >= STAMP_BITS'(bgd_pkg::BGD_HINT2_LO)
				&& hold_el < STAMP_BITS'(bgd_pkg::BGD_HINT2_HI)) begin
				hint = bgd_pkg::BGD_HINT_SECOND;
			end
		end
	end

	always_comb begin
		res       = '0;
		res.tally = count_q;
		if (cfg.enable) begin
			res.tap        = valid_tap;
			res.tally      = count_d;
			res.multi_tap  = valid_tap && multi;
			res.long_press = long_hit;
			res.hint       = hint;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q        <= 1'b0;
			press_stamp_q <= '0;
			long_fired_q  <= 1'b0;
			count_q       <= 4'd0;
			count_stamp_q <= '0;
		end else if (step && cfg.enable) begin
			if (pressed) begin
				if (!held_q) begin
					held_q        <= 1'b1;
					press_stamp_q <= now;
					long_fired_q  <= 1'b0;
				end else if (long_hit) begin
					long_fired_q <= 1'b1;
				end
			end else begin
				held_q <= 1'b0;
			end
			if (restamp) begin
				count_stamp_q <= now;
			end
			count_q <= count_d;
		end
	end

endmodule

FILE: src/button_gesture_detector.sv
`timescale 1ns / 1ps

// Channel   Dir  Modport      Transaction
// samples   in   sink         first_pressed, second_pressed, now_ms
// results   out  source       first_tap .. hold_hint, one per sample
// cfg_*     in   write port   register index and data, no read-back
//
// Every sample passes from acceptance to result through the input register,
// then the gesture logic updates state and loads the result register.
// One sample is accepted per cycle while results are taken.
// A stalled result holds the result register and, once the input register is
// also full, samples.ready drops. Reset clears the valid flags and the gesture
// state and loads the register defaults; detection starts disabled.
module button_gesture_detector #(
	parameter int unsigned STAMP_BITS = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	bgd_in_if.sink                                 samples,
	bgd_out_if.source                              results,
	input  logic                                   cfg_wr_en,
	input  logic [bgd_pkg::BGD_CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [bgd_pkg::BGD_CFG_DATA_BITS-1:0]  cfg_wdata
);

	bgd_pkg::bgd_cfg_t        cfg_q;

	// input register
	logic                     valid_s1;
	logic                     first_s1;
	logic                     second_s1;
	logic [31:0]              now_s1;

	// result register
	logic                     valid_s2;
	bgd_pkg::bgd_first_res_t  first_res_s2;
	bgd_pkg::bgd_second_res_t second_res_s2;

	logic                     out_free;
	logic                     step;
	logic [STAMP_BITS-1:0]    now_stamp;
	bgd_pkg::bgd_first_res_t  first_res;
	bgd_pkg::bgd_second_res_t second_res;

	assign out_free      = !valid_s2 || results.ready;
	assign step          = valid_s1 && out_free;
	assign samples.ready = !valid_s1 || out_free;
	// stamps wrap at STAMP_BITS: narrower keeps the low bits, wider zero-extends
	assign now_stamp     = STAMP_BITS'(now_s1);

	// config writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable           <= 1'b0;
			cfg_q.tap_min_ms       <= 10'd50;
			cfg_q.double_window_ms <= 16'd500;
			cfg_q.triple_window_ms <= 16'd1500;
			cfg_q.long_hold_ms     <= 16'd3000;
			cfg_q.taps_needed      <= 4'd3;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				bgd_pkg::BGD_REG_ENABLE:        cfg_q.enable           <= cfg_wdata[0];
				bgd_pkg::BGD_REG_TAP_MIN:       cfg_q.tap_min_ms       <= cfg_wdata[9:0];
				bgd_pkg::BGD_REG_DOUBLE_WINDOW: cfg_q.double_window_ms <= cfg_wdata;
				bgd_pkg::BGD_REG_TRIPLE_WINDOW: cfg_q.triple_window_ms <= cfg_wdata;
				bgd_pkg::BGD_REG_LONG_PRESS:    cfg_q.long_hold_ms     <= cfg_wdata;
				bgd_pkg::BGD_REG_TAPS_NEEDED:   cfg_q.taps_needed      <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			first_s1  <= samples.first_pressed;
			second_s1 <= samples.second_pressed;
			now_s1    <= samples.now_ms;
		end
	end

	bgd_first #(
		.STAMP_BITS(STAMP_BITS)
	) u_first (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cfg    (cfg_q),
		.pressed(first_s1),
		.now    (now_stamp),
		.res    (first_res)
	);

	bgd_second #(
		.STAMP_BITS(STAMP_BITS)
	) u_second (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cfg    (cfg_q),
		.pressed(second_s1),
		.now    (now_stamp),
		.res    (second_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			first_res_s2  <= first_res;
			second_res_s2 <= second_res;
		end
	end

	assign results.valid             = valid_s2;
	assign results.first_tap         = first_res_s2.tap;
	assign results.first_tap_pending = first_res_s2.pending;
	assign results.double_tap        = first_res_s2.double_tap;
	assign results.second_tap        = second_res_s2.tap;
	assign results.tap_tally         = second_res_s2.tally;
	assign results.multi_tap         = second_res_s2.multi_tap;
	assign results.long_press        = second_res_s2.long_press;
	assign results.hold_hint         = second_res_s2.hint;

endmodule

FILE: bench/tb_button_gesture_detector.sv
`timescale 1ns / 1ps

// Self-checking bench for the two-button gesture detector.
module tb_button_gesture_detector;

	// Sample-to-result delay, and the drain margin derived from it.
	localparam int unsigned LATENCY         = 2;
	localparam int unsigned DRAIN_CYCLES    = 4 * LATENCY;
	localparam int unsigned HOLD_OFF_CYCLES = 200;
	localparam int unsigned CYCLE_LIMIT     = 200000;

	// One result transaction as the predictor sees it
	typedef struct packed {
		bgd_pkg::bgd_first_res_t  first;
		bgd_pkg::bgd_second_res_t second;
	} gesture_t;

	typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	// Directed stimulus: either a sample or a register write. A sample row with
	// typed set carries its own expected result, the rest go to the predictor.
	typedef struct {
		row_kind_t             kind;
		logic                  p1;
		logic                  p2;
		logic [31:0]           stamp;
		bgd_pkg::bgd_reg_idx_t idx;
		logic [15:0]           data;
		bit                    typed;
		gesture_t              want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [bgd_pkg::BGD_CFG_IDX_BITS-1:0]  cfg_index;
	logic [bgd_pkg::BGD_CFG_DATA_BITS-1:0] cfg_wdata;

	bgd_in_if  samples_if();
	bgd_out_if results_if();

	button_gesture_detector u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples_if),
		.results   (results_if),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	int unsigned cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Watchdog: a stuck handshake or a lost result ends up here
	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	// Idle rates in percent, and the request for one long receiver hold-off
	int unsigned send_gap_pct = 33;
	int unsigned recv_gap_pct = 50;
	bit          stall_request = 1'b0;

	int unsigned mismatch_count = 0;
	gesture_t    predicted_gestures[$];
	row_t        directed_rows[$];

	// ------------------------------------------------------------------
	// Predictor: shadow of the registers and of the gesture state
	// ------------------------------------------------------------------
	bgd_pkg::bgd_cfg_t cfg_shadow;
	logic        btn1_down   = 1'b0;
	logic [31:0] btn1_stamp  = '0;
	logic        pair_open   = 1'b0;
	logic [31:0] pair_stamp  = '0;
	logic        btn2_down   = 1'b0;
	logic [31:0] btn2_stamp  = '0;
	logic        long_done   = 1'b0;
	logic [3:0]  tally       = '0;
	logic [31:0] tally_stamp = '0;

	function automatic bit is_tap(input logic [31:0] hold);
		return hold >= cfg_shadow.tap_min_ms && hold < bgd_pkg::BGD_TAP_MAX_MS;
	endfunction

	// Works out the result of one sample and moves the shadow state on.
	// All differences are 32-bit, so timestamp wrap comes for free.
	function automatic gesture_t predict_gesture(input logic p1, p2,
			input logic [31:0] stamp);
		gesture_t    r;
		logic [31:0] hold;
		r = '0;
		if (cfg_shadow.enable) begin
			// first button: pair of taps
			if (p1 && !btn1_down) begin
				btn1_down  = 1'b1;
				btn1_stamp = stamp;
			end else if (!p1 && btn1_down) begin
				btn1_down = 1'b0;
				if (is_tap(stamp - btn1_stamp)) begin
					r.first.tap = 1'b1;
					if (!pair_open) begin
						pair_open       = 1'b1;
						pair_stamp      = stamp;
						r.first.pending = 1'b1;
					end else begin
						// a late second tap just closes the pair
						if ((stamp - pair_stamp) <= cfg_shadow.double_window_ms)
							r.first.double_tap = 1'b1;
						pair_open = 1'b0;
					end
				end
			end
			if (pair_open && (stamp - pair_stamp) > cfg_shadow.double_window_ms)
				pair_open = 1'b0;

			// second button: hints, long press, counted taps
			if (p2) begin
				if (!btn2_down) begin
					btn2_down  = 1'b1;
					btn2_stamp = stamp;
					long_done  = 1'b0;
				end else if (!long_done) begin
					hold = stamp - btn2_stamp;
					if (hold >= bgd_pkg::BGD_HINT1_LO && hold < bgd_pkg::BGD_HINT1_HI)
						r.second.hint = bgd_pkg::BGD_HINT_FIRST;
					else if (hold >= bgd_pkg::BGD_HINT2_LO && hold < bgd_pkg::BGD_HINT2_HI)
						r.second.hint = bgd_pkg::BGD_HINT_SECOND;
					if (hold >= cfg_shadow.long_hold_ms) begin
						r.second.long_press = 1'b1;
						long_done           = 1'b1;
					end
				end
			end else begin
				if (btn2_down && !long_done && is_tap(stamp - btn2_stamp)) begin
					if (tally == 4'd0)
						tally_stamp = stamp;
					if ((stamp - tally_stamp) <= cfg_shadow.triple_window_ms) begin
						tally = tally + 4'd1;
					end else begin
						// window ran out: this tap opens a fresh count
						tally       = 4'd1;
						tally_stamp = stamp;
					end
					r.second.tap = 1'b1;
					if (tally >= cfg_shadow.taps_needed) begin
						r.second.multi_tap = 1'b1;
						tally              = 4'd0;
					end
				end
				btn2_down = 1'b0;
			end
			if (tally != 4'd0 && (stamp - tally_stamp) > cfg_shadow.triple_window_ms)
				tally = 4'd0;
		end
		r.second.tally = tally;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	function automatic void check_field(input string name, input logic [3:0] want,
			input logic [3:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		gesture_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (predicted_gestures.size() == 0) begin
				$error("result transaction with no sample outstanding");
				mismatch_count++;
			end else begin
				want = predicted_gestures.pop_front();
				check_field("first_tap", want.first.tap, results_if.first_tap);
				check_field("first_tap_pending", want.first.pending,
					results_if.first_tap_pending);
				check_field("double_tap", want.first.double_tap, results_if.double_tap);
				check_field("second_tap", want.second.tap, results_if.second_tap);
				check_field("tap_tally", want.second.tally, results_if.tap_tally);
				check_field("multi_tap", want.second.multi_tap, results_if.multi_tap);
				check_field("long_press", want.second.long_press, results_if.long_press);
				check_field("hold_hint", want.second.hint, results_if.hold_hint);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side: random back-pressure plus one long hold-off on request.
	// The hold-off is counted here so the sender keeps offering meanwhile.
	// ------------------------------------------------------------------
	initial begin : result_sink
		int unsigned held;
		results_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				results_if.ready <= 1'b0;
				held = 0;
				while (held < HOLD_OFF_CYCLES) begin
					@(posedge clk);
					held++;
				end
			end
			results_if.ready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// ------------------------------------------------------------------
	// Sample side
	// ------------------------------------------------------------------
	// Offers one sample, optionally after random idle cycles, and records the
	// expected result once the transaction has gone through.
	task automatic push_sample(input logic p1, p2, input logic [31:0] stamp,
			input bit typed, input gesture_t want);
		gesture_t guess;
		while ($urandom_range(99) < send_gap_pct) begin
			samples_if.valid <= 1'b0;
			@(posedge clk);
		end
		samples_if.valid          <= 1'b1;
		samples_if.first_pressed  <= p1;
		samples_if.second_pressed <= p2;
		samples_if.now_ms         <= stamp;
		@(posedge clk);
		while (!samples_if.ready) @(posedge clk);
		guess = predict_gesture(p1, p2, stamp);
		predicted_gestures.push_back(typed ? want : guess);
	endtask

	// Every sample gives a result, so an empty queue means the block is
	// quiet; the extra cycles cover the pipeline anyway.
	task automatic wait_idle();
		samples_if.valid <= 1'b0;
		while (predicted_gestures.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input bgd_pkg::bgd_reg_idx_t idx, input logic [15:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		unique case (idx)
			bgd_pkg::BGD_REG_ENABLE:        cfg_shadow.enable           = data[0];
			bgd_pkg::BGD_REG_TAP_MIN:       cfg_shadow.tap_min_ms       = data[9:0];
			bgd_pkg::BGD_REG_DOUBLE_WINDOW: cfg_shadow.double_window_ms = data;
			bgd_pkg::BGD_REG_TRIPLE_WINDOW: cfg_shadow.triple_window_ms = data;
			bgd_pkg::BGD_REG_LONG_PRESS:    cfg_shadow.long_hold_ms     = data;
			bgd_pkg::BGD_REG_TAPS_NEEDED:   cfg_shadow.taps_needed      = data[3:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input bgd_pkg::bgd_cfg_t s);
		wait_idle();
		write_reg(bgd_pkg::BGD_REG_ENABLE, 16'(s.enable));
		write_reg(bgd_pkg::BGD_REG_TAP_MIN, 16'(s.tap_min_ms));
		write_reg(bgd_pkg::BGD_REG_DOUBLE_WINDOW, s.double_window_ms);
		write_reg(bgd_pkg::BGD_REG_TRIPLE_WINDOW, s.triple_window_ms);
		write_reg(bgd_pkg::BGD_REG_LONG_PRESS, s.long_hold_ms);
		write_reg(bgd_pkg::BGD_REG_TAPS_NEEDED, 16'(s.taps_needed));
	endtask

	function automatic bgd_pkg::bgd_cfg_t random_settings();
		bgd_pkg::bgd_cfg_t s;
		s.enable           = 1'b1;
		s.tap_min_ms       = 10'($urandom_range(0, 300));
		s.double_window_ms = 16'($urandom_range(100, 1500));
		s.triple_window_ms = 16'($urandom_range(500, 4000));
		s.long_hold_ms     = 16'($urandom_range(500, 4000));
		s.taps_needed      = 4'($urandom_range(1, 6));
		return s;
	endfunction

	function automatic void add_sample(input logic p1, p2, input logic [31:0] stamp,
			input bit typed = 1'b0, input gesture_t want = '0);
		row_t r;
		r.kind  = ROW_SAMPLE;
		r.p1    = p1;
		r.p2    = p2;
		r.stamp = stamp;
		r.idx   = bgd_pkg::BGD_REG_ENABLE;
		r.data  = '0;
		r.typed = typed;
		r.want  = want;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_write(input bgd_pkg::bgd_reg_idx_t idx,
			input logic [15:0] data);
		row_t r;
		r.kind  = ROW_WRITE;
		r.p1    = 1'b0;
		r.p2    = 1'b0;
		r.stamp = '0;
		r.idx   = idx;
		r.data  = data;
		r.typed = 1'b0;
		r.want  = '0;
		directed_rows.push_back(r);
	endfunction

	// ------------------------------------------------------------------
	// Random gestures: each button toggles after a random span of ms, the
	// timestamp creeps forward in small steps so hint windows get sampled.
	// A small share of samples is noise that breaks the sequences.
	// ------------------------------------------------------------------
	logic        lvl1, lvl2;
	int          left1, left2;
	logic [31:0] run_stamp;

	function automatic int pick_span(input logic pressed);
		int unsigned roll;
		roll = $urandom_range(99);
		if (pressed) begin
			if (roll < 60) return $urandom_range(20, 1100);
			if (roll < 85) return $urandom_range(900, 3500);
			if (roll < 95) return $urandom_range(0, 60);
			return $urandom_range(3500, 70000);
		end
		if (roll < 70) return $urandom_range(0, 600);
		if (roll < 95) return $urandom_range(600, 2500);
		return $urandom_range(2500, 70000);
	endfunction

	task automatic roll_sample(output logic p1, p2, output logic [31:0] stamp);
		int unsigned roll;
		int unsigned step;
		roll = $urandom_range(99);
		if (roll < 8) begin
			p1    = 1'($urandom);
			p2    = 1'($urandom);
			stamp = $urandom;
		end else begin
			roll = $urandom_range(99);
			if (roll < 85)      step = $urandom_range(0, 60);
			else if (roll < 95) step = $urandom_range(61, 400);
			else                step = $urandom_range(401, 20000);
			run_stamp = run_stamp + step;
			left1 = left1 - int'(step);
			if (left1 <= 0) begin
				lvl1  = !lvl1;
				left1 = pick_span(lvl1);
			end
			left2 = left2 - int'(step);
			if (left2 <= 0) begin
				lvl2  = !lvl2;
				left2 = pick_span(lvl2);
			end
			p1    = lvl1;
			p2    = lvl2;
			stamp = run_stamp;
		end
	endtask

	// One random phase; stall_at picks the sample where the long receiver
	// hold-off starts (negative for none).
	task automatic run_phase(input int items, input int stall_at);
		logic        p1, p2;
		logic [31:0] stamp;
		// start anywhere, now and then just short of the wrap
		if ($urandom_range(1))
			run_stamp = $urandom;
		else
			run_stamp = 32'hFFFF_F000 | 32'($urandom_range(0, 4095));
		for (int i = 0; i < items; i++) begin
			if (i == stall_at)
				stall_request = 1'b1;
			roll_sample(p1, p2, stamp);
			push_sample(p1, p2, stamp, 1'b0, '0);
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		bgd_pkg::bgd_cfg_t s;
		arst_n                    <= 1'b0;
		samples_if.valid          <= 1'b0;
		samples_if.first_pressed  <= 1'b0;
		samples_if.second_pressed <= 1'b0;
		samples_if.now_ms         <= '0;
		cfg_wr_en                 <= 1'b0;
		cfg_index                 <= bgd_pkg::BGD_REG_ENABLE;
		cfg_wdata                 <= '0;
		cfg_shadow = '{1'b0, 10'd50, 16'd500, 16'd1500, 16'd3000, 4'd3};
		lvl1  = 1'b0;
		lvl2  = 1'b0;
		left1 = pick_span(1'b0);
		left2 = pick_span(1'b0);

		// Out of reset detection is off: buttons are ignored, all zero
		add_sample(1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, '0);
		add_write(bgd_pkg::BGD_REG_ENABLE, 16'd1);
		// first button: pair of taps, then a lone tap that times out
		add_sample(1'b1, 1'b0, 32'd1000);
		add_sample(1'b0, 1'b0, 32'd1100);
		add_sample(1'b1, 1'b0, 32'd1200);
		add_sample(1'b0, 1'b0, 32'd1300);
		add_sample(1'b1, 1'b0, 32'd2000);
		add_sample(1'b0, 1'b0, 32'd2060);
		add_sample(1'b0, 1'b0, 32'd2600);
		// second button: three short taps make a multi-tap
		add_sample(1'b0, 1'b1, 32'd3000);
		add_sample(1'b0, 1'b0, 32'd3100);
		add_sample(1'b0, 1'b1, 32'd3200);
		add_sample(1'b0, 1'b0, 32'd3300);
		add_sample(1'b0, 1'b1, 32'd3400);
		add_sample(1'b0, 1'b0, 32'd3500);
		// long hold: first hint, then second hint and long press together;
		// the release after the long press is not a tap
		add_write(bgd_pkg::BGD_REG_LONG_PRESS, 16'd2050);
		add_sample(1'b0, 1'b1, 32'd5000);
		add_sample(1'b0, 1'b1, 32'd6050);
		add_sample(1'b0, 1'b1, 32'd7050);
		add_sample(1'b0, 1'b0, 32'd7100);
		// late tap: second tap lands after the counting window closed
		add_sample(1'b0, 1'b1, 32'd10900);
		add_sample(1'b0, 1'b0, 32'd11000);
		add_sample(1'b0, 1'b1, 32'd12400);
		add_sample(1'b0, 1'b0, 32'd12600);
		// zero taps needed and no minimum hold; taps across the wrap and
		// a press and release seen at the same timestamp
		add_write(bgd_pkg::BGD_REG_TAPS_NEEDED, 16'd0);
		add_write(bgd_pkg::BGD_REG_TAP_MIN, 16'd0);
		add_sample(1'b1, 1'b1, 32'hFFFF_FFF0);
		add_sample(1'b0, 1'b0, 32'h0000_0040);
		add_sample(1'b1, 1'b1, 32'h0000_0100);
		add_sample(1'b0, 1'b0, 32'h0000_0100);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				wait_idle();
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				push_sample(directed_rows[i].p1, directed_rows[i].p2,
					directed_rows[i].stamp, directed_rows[i].typed, directed_rows[i].want);
			end
		end

		// Sender idles a third of the time, receiver half
		apply_settings('{1'b1, 10'd50, 16'd500, 16'd1500, 16'd3000, 4'd3});
		run_phase(350, 120);
		// extremes: no minimum hold, widest counting window, long press at once
		apply_settings('{1'b1, 10'd0, 16'd0, 16'd65535, 16'd0, 4'd15});
		run_phase(300, -1);

		// Roles swapped
		send_gap_pct = 50;
		recv_gap_pct = 33;
		// tightest extremes: no valid tap is possible at all
		apply_settings('{1'b1, 10'd1000, 16'd65535, 16'd0, 16'd65535, 4'd1});
		run_phase(250, -1);
		apply_settings(random_settings());
		run_phase(350, -1);

		// No idling on either side
		send_gap_pct = 0;
		recv_gap_pct = 0;
		// detection off: state must hold across the whole stretch
		s        = random_settings();
		s.enable = 1'b0;
		apply_settings(s);
		run_phase(60, -1);
		apply_settings(random_settings());
		run_phase(350, -1);
		s             = random_settings();
		s.taps_needed = 4'd0;
		apply_settings(s);
		run_phase(300, -1);

		wait_idle();
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
